### rtl/utf8_identifier_protector_top_defines.svh
// Assertion macros for the identifier protector.
// Taken in by the top level; no other dependencies.
`ifndef UTF8_IDENTIFIER_PROTECTOR_TOP_DEFINES_SVH
`define UTF8_IDENTIFIER_PROTECTOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define UIP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("uip assertion failed");
// Antecedent implies consequent in the next cycle.
`define UIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("uip assertion failed");
`else
`define UIP_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define UIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/uip_pkg.sv
// Shared types and constants of the identifier protector.
// No dependencies; used by every module of the block.
`default_nettype none
package uip_pkg;

	localparam int CP_W   = 21;
	localparam int STEP_W = 3;

	localparam logic [7:0]      SPACE_BYTE     = 8'h20;
	localparam logic [7:0]      CONT_MASK      = 8'hC0;
	localparam logic [7:0]      CONT_TAG       = 8'h80;
	localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;
	localparam logic [6:0]      DASH_CHAR      = 7'h2D;
	localparam logic [6:0]      UNDER_CHAR     = 7'h5F;

	typedef struct packed {
		logic [7:0] name_byte;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		logic [6:0] out_char;
		logic       char_present;
		logic       end_of_name;
	} out_item_t;

	typedef enum logic [1:0] {
		CMD_CHAR,
		CMD_PROT,
		CMD_END
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t       kind;
		logic [CP_W-1:0] value;
		logic            last;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage
`default_nettype wire

### rtl/uip_front.sv
// Front part: accepts bytes, tracks UTF-8 decode state, issues commands.
// Depends on uip_pkg.
`default_nettype none
module uip_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              byte_valid,
	input  wire uip_pkg::in_item_t byte_item,
	input  wire logic              queue_full,
	output logic                   push,
	output uip_pkg::cmd_t          push_cmd
);

	logic                      in_space_run_q;
	logic [uip_pkg::CP_W-1:0]  code_accum_q;
	logic [1:0]                bytes_pending_q;

	logic                      nxt_run;
	logic [uip_pkg::CP_W-1:0]  nxt_acc;
	logic [1:0]                nxt_pend;
	logic                      has_out;
	uip_pkg::cmd_kind_t        kind;
	logic [uip_pkg::CP_W-1:0]  value;
	logic [uip_pkg::CP_W-1:0]  acc_shift;
	logic [7:0]                b;
	logic                      accept;
	logic                      alnum;

	assign b         = byte_item.name_byte;
	assign accept    = byte_valid && !queue_full;
	assign acc_shift = {code_accum_q[uip_pkg::CP_W-7:0], b[5:0]};
	assign alnum     = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
	                   (b >= 8'h61 && b <= 8'h7A);

	// Classify the byte and work out the next decode state
	always_comb begin
		nxt_run  = in_space_run_q;
		nxt_acc  = code_accum_q;
		nxt_pend = bytes_pending_q;
		has_out  = 1'b0;
		kind     = uip_pkg::CMD_CHAR;
		value    = '0;
		if (b == uip_pkg::SPACE_BYTE) begin
			nxt_pend = '0;
			nxt_acc  = '0;
			nxt_run  = 1'b1;
			if (!in_space_run_q) begin
				has_out = 1'b1;
				value   = {14'd0, uip_pkg::DASH_CHAR};
			end
		end else begin
			nxt_run = 1'b0;
			if ((b & uip_pkg::CONT_MASK) == uip_pkg::CONT_TAG) begin
				if (bytes_pending_q != 2'd0) begin
					nxt_pend = bytes_pending_q - 2'd1;
					if (bytes_pending_q == 2'd1) begin
						has_out = 1'b1;
						kind    = uip_pkg::CMD_PROT;
						value   = acc_shift;
						nxt_acc = '0;
					end else begin
						nxt_acc = acc_shift;
					end
				end else begin
					has_out = 1'b1;
					kind    = uip_pkg::CMD_PROT;
					value   = uip_pkg::REPLACEMENT_CP;
				end
			end else begin
				nxt_pend = '0;
				nxt_acc  = '0;
				priority if (alnum) begin
					has_out = 1'b1;
					value   = {14'd0, b[6:0]};
				end else if (b < 8'h80) begin
					has_out = 1'b1;
					kind    = uip_pkg::CMD_PROT;
					value   = {14'd0, b[6:0]};
				end else if (b < 8'hE0) begin
					nxt_acc  = {16'd0, b[4:0]};
					nxt_pend = 2'd1;
				end else if (b < 8'hF0) begin
					nxt_acc  = {17'd0, b[3:0]};
					nxt_pend = 2'd2;
				end else if (b < 8'hF8) begin
					nxt_acc  = {18'd0, b[2:0]};
					nxt_pend = 2'd3;
				end else begin
					has_out = 1'b1;
					kind    = uip_pkg::CMD_PROT;
					value   = uip_pkg::REPLACEMENT_CP;
				end
			end
		end
	end

	// Queue a command when the byte yields output or ends the name
	assign push          = accept && (has_out || byte_item.final_byte);
	assign push_cmd.kind = has_out ? kind : uip_pkg::CMD_END;
	assign push_cmd.value = has_out ? value : '0;
	assign push_cmd.last = byte_item.final_byte;

	// Hold decode state; drop it all at the end of a name
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_space_run_q  <= 1'b0;
			code_accum_q    <= '0;
			bytes_pending_q <= '0;
		end else if (accept) begin
			if (byte_item.final_byte) begin
				in_space_run_q  <= 1'b0;
				code_accum_q    <= '0;
				bytes_pending_q <= '0;
			end else begin
				in_space_run_q  <= nxt_run;
				code_accum_q    <= nxt_acc;
				bytes_pending_q <= nxt_pend;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/uip_queue.sv
// Short command queue between the front and back parts.
// Depends on uip_pkg.
`default_nettype none
module uip_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire uip_pkg::cmd_t  push_cmd,
	input  wire logic           pop,
	output uip_pkg::cmd_t       head,
	output uip_pkg::queue_status_t status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	uip_pkg::cmd_t    entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head         = entry_q[rd_ptr_q];
	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### rtl/uip_back.sv
// Back part: expands queued commands into output characters, one per cycle while the output is not stalled.
// Depends on uip_pkg.
`default_nettype none
module uip_back (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire uip_pkg::cmd_t          head,
	input  wire logic                   queue_empty,
	output logic                        pop,
	output logic                        char_valid,
	input  wire logic                   char_stall,
	output uip_pkg::out_item_t          char_item
);

	logic [uip_pkg::STEP_W-1:0] step_q;
	logic                       char_valid_q;
	uip_pkg::out_item_t         char_item_s1;

	logic                       load;
	logic                       long_cp;
	logic                       underscore;
	logic                       last_step;
	logic [uip_pkg::STEP_W-1:0] nib_idx;
	logic [3:0]                 nib;
	logic [6:0]                 hex_char;
	uip_pkg::out_item_t         nxt_item;

	assign load    = !char_valid_q || !char_stall;
	assign long_cp = |head.value[uip_pkg::CP_W-1:16];
	assign nib_idx = long_cp ? (3'd7 - step_q) : (3'd4 - step_q);

	// Pick the hex digit for this step
	always_comb begin
		unique case (nib_idx)
			3'd0:    nib = head.value[3:0];
			3'd1:    nib = head.value[7:4];
			3'd2:    nib = head.value[11:8];
			3'd3:    nib = head.value[15:12];
			3'd4:    nib = head.value[19:16];
			3'd5:    nib = {3'd0, head.value[20]};
			default: nib = 4'd0;
		endcase
		hex_char = (nib < 4'd10) ? (7'h30 + {3'd0, nib}) : (7'h57 + {3'd0, nib});
	end

	// Build the result for the current step of the head command
	always_comb begin
		underscore = long_cp ? (step_q < 3'd2) : (step_q == 3'd0);
		last_step  = 1'b1;
		nxt_item   = '0;
		unique case (head.kind)
			uip_pkg::CMD_CHAR: begin
				nxt_item.out_char     = head.value[6:0];
				nxt_item.char_present = 1'b1;
			end
			uip_pkg::CMD_PROT: begin
				last_step             = long_cp ? (step_q == 3'd7) : (step_q == 3'd4);
				nxt_item.out_char     = underscore ? uip_pkg::UNDER_CHAR : hex_char;
				nxt_item.char_present = 1'b1;
			end
			default: begin
				nxt_item.out_char     = '0;
				nxt_item.char_present = 1'b0;
			end
		endcase
		nxt_item.end_of_name = head.last && last_step;
	end

	assign pop        = load && !queue_empty && last_step;
	assign char_valid = char_valid_q;
	assign char_item  = char_item_s1;

	// Hold the output register while stalled; advance otherwise
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_valid_q <= 1'b0;
			step_q       <= '0;
		end else if (load) begin
			char_valid_q <= !queue_empty;
			if (!queue_empty) begin
				step_q <= last_step ? '0 : step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !queue_empty) begin
			char_item_s1 <= nxt_item;
		end
	end

endmodule
`default_nettype wire

### rtl/utf8_identifier_protector_top.sv
// Path: an accepted byte is written into the queue, then its first result is registered at the back part's output.
// Throughput: one byte per cycle while each byte yields at most one character and the
// output is not stalled; an escaped character is written out as _xxxx or __xxxxxx,
// one character per cycle by the back part into its output register, holding the queue meanwhile.
// Reset: arst_n clears decode state, queue and output valid at once.
`default_nettype none
`include "utf8_identifier_protector_top_defines.svh"
module utf8_identifier_protector_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               byte_valid,
	output logic                    byte_stall,
	input  wire uip_pkg::in_item_t  byte_item,
	output logic                    char_valid,
	input  wire logic               char_stall,
	output uip_pkg::out_item_t      char_item
);

	logic                   push;
	logic                   pop;
	uip_pkg::cmd_t          push_cmd;
	uip_pkg::cmd_t          head;
	uip_pkg::queue_status_t q_status;
	logic                   bare_out;
	logic                   bare_ok;

	assign byte_stall = q_status.full;

	uip_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_item  (byte_item),
		.queue_full (q_status.full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	uip_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	uip_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.queue_empty (q_status.empty),
		.pop         (pop),
		.char_valid  (char_valid),
		.char_stall  (char_stall),
		.char_item   (char_item)
	);

	// Checks on the front/back hand-over and the end marker
	assign bare_out = char_valid && !char_item.char_present;
	assign bare_ok  = char_item.end_of_name && (char_item.out_char == 7'd0);

	`UIP_ASSERT_NOW(a_no_push_full, clk, arst_n, push, !q_status.full)
	`UIP_ASSERT_NOW(a_no_pop_empty, clk, arst_n, pop, !q_status.empty)
	`UIP_ASSERT_NOW(a_bare_ends, clk, arst_n, bare_out, bare_ok)
	`UIP_ASSERT_NEXT(a_push_fills, clk, arst_n, push && !pop, !q_status.empty)

endmodule
`default_nettype wire
